/* hdl/ceau_pkg.sv */
// Package: types and constants shared by the effective address unit.
`timescale 1ns / 1ps
`default_nettype none

package ceau_pkg;

    localparam logic [15:0] PAGE_MASK = 16'hFF00;
    localparam logic [15:0] BYTE_MASK = 16'h00FF;

    typedef enum logic {
        CMD_RESOLVE = 1'b0,
        CMD_POINTER = 1'b1
    } t_cmd;

    typedef enum logic [3:0] {
        MODE_IMPLIED   = 4'd0,
        MODE_IMMEDIATE = 4'd1,
        MODE_ZP        = 4'd2,
        MODE_ZP_X      = 4'd3,
        MODE_ZP_Y      = 4'd4,
        MODE_ABS       = 4'd5,
        MODE_ABS_X     = 4'd6,
        MODE_ABS_Y     = 4'd7,
        MODE_RELATIVE  = 4'd8,
        MODE_INDIRECT  = 4'd9,
        MODE_ZP_X_IND  = 4'd10,
        MODE_ZP_IND_Y  = 4'd11
    } t_mode;

    typedef struct packed {
        logic        command;
        logic [3:0]  mode;
        logic [15:0] pc;
        logic [7:0]  operand_lo;
        logic [7:0]  operand_hi;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  pointer_lo;
        logic [7:0]  pointer_hi;
    } t_in_item;

    typedef struct packed {
        logic [15:0] address;
        logic        page_crossed;
        logic [15:0] next_pc;
        logic        needs_pointer;
        logic [15:0] pointer_lo_address;
        logic [15:0] pointer_hi_address;
        logic        protocol_error;
    } t_out_item;

    typedef struct packed {
        logic        valid;
        logic        add_y;
        logic [7:0]  index_y;
        logic [15:0] next_pc;
    } t_pend;

    function automatic logic page_diff(input logic [15:0] a, input logic [15:0] b);
        return (a & PAGE_MASK) != (b & PAGE_MASK);
    endfunction

endpackage

`default_nettype wire

/* hdl/ceau_resolve.sv */
// Combinational address resolution for one transaction and the next pending state.
`timescale 1ns / 1ps
`default_nettype none

module ceau_resolve (
    input  var ceau_pkg::t_in_item  i_item,
    input  var ceau_pkg::t_pend     i_pend,
    output ceau_pkg::t_out_item     o_res,
    output ceau_pkg::t_pend         o_pend
);

    logic [15:0] word;
    logic [15:0] pc1;
    logic [15:0] pc2;
    logic [15:0] sum_x;
    logic [15:0] sum_y;
    logic [15:0] rel;
    logic [15:0] base;
    logic [15:0] base_y;
    logic [7:0]  zp_x;

    assign word   = {i_item.operand_hi, i_item.operand_lo};
    assign pc1    = i_item.pc + 16'd1;
    assign pc2    = i_item.pc + 16'd2;
    assign sum_x  = word + {8'h00, i_item.index_x};
    assign sum_y  = word + {8'h00, i_item.index_y};
    assign rel    = pc1 + {{8{i_item.operand_lo[7]}}, i_item.operand_lo};
    assign base   = {i_item.pointer_hi, i_item.pointer_lo};
    assign base_y = base + {8'h00, i_pend.index_y};
    assign zp_x   = i_item.operand_lo + i_item.index_x;

    always_comb begin
        o_res  = '0;
        o_pend = i_pend;
        if (ceau_pkg::t_cmd'(i_item.command) == ceau_pkg::CMD_POINTER) begin
            if (i_pend.valid) begin
                o_res.next_pc = i_pend.next_pc;
                if (i_pend.add_y) begin
                    o_res.address      = base_y;
                    o_res.page_crossed = ceau_pkg::page_diff(base, base_y);
                end else begin
                    o_res.address = base;
                end
                o_pend.valid = 1'b0;
                o_pend.add_y = 1'b0;
            end else begin
                o_res.protocol_error = 1'b1;
            end
        end else begin
            o_pend.valid = 1'b0;
            o_pend.add_y = 1'b0;
            unique case (ceau_pkg::t_mode'(i_item.mode))
                ceau_pkg::MODE_IMMEDIATE: begin
                    o_res.address = i_item.pc;
                    o_res.next_pc = pc1;
                end
                ceau_pkg::MODE_ZP: begin
                    o_res.address = {8'h00, i_item.operand_lo};
                    o_res.next_pc = pc1;
                end
                ceau_pkg::MODE_ZP_X: begin
                    o_res.address = {8'h00, zp_x};
                    o_res.next_pc = pc1;
                end
                ceau_pkg::MODE_ZP_Y: begin
                    o_res.address = {8'h00, i_item.operand_lo + i_item.index_y};
                    o_res.next_pc = pc1;
                end
                ceau_pkg::MODE_ABS: begin
                    o_res.address = word;
                    o_res.next_pc = pc2;
                end
                ceau_pkg::MODE_ABS_X: begin
                    o_res.address      = sum_x;
                    o_res.page_crossed = ceau_pkg::page_diff(word, sum_x);
                    o_res.next_pc      = pc2;
                end
                ceau_pkg::MODE_ABS_Y: begin
                    o_res.address      = sum_y;
                    o_res.page_crossed = ceau_pkg::page_diff(word, sum_y);
                    o_res.next_pc      = pc2;
                end
                ceau_pkg::MODE_RELATIVE: begin
                    o_res.address      = rel;
                    o_res.page_crossed = ceau_pkg::page_diff(pc1, rel);
                    o_res.next_pc      = pc1;
                end
                ceau_pkg::MODE_INDIRECT: begin
                    o_res.next_pc            = pc2;
                    o_res.needs_pointer      = 1'b1;
                    o_res.pointer_lo_address = word;
                    // high byte stays in the same page
                    o_res.pointer_hi_address = (word & ceau_pkg::PAGE_MASK)
                                             | ((word + 16'd1) & ceau_pkg::BYTE_MASK);
                end
                ceau_pkg::MODE_ZP_X_IND: begin
                    o_res.next_pc            = pc1;
                    o_res.needs_pointer      = 1'b1;
                    o_res.pointer_lo_address = {8'h00, zp_x};
                    o_res.pointer_hi_address = {8'h00, zp_x + 8'd1};
                end
                ceau_pkg::MODE_ZP_IND_Y: begin
                    o_res.next_pc            = pc1;
                    o_res.needs_pointer      = 1'b1;
                    o_res.pointer_lo_address = {8'h00, i_item.operand_lo};
                    o_res.pointer_hi_address = {8'h00, i_item.operand_lo + 8'd1};
                    o_pend.add_y             = 1'b1;
                    o_pend.index_y           = i_item.index_y;
                end
                default: begin
                    o_res.next_pc = i_item.pc;
                end
            endcase
            if (o_res.needs_pointer) begin
                o_pend.valid   = 1'b1;
                o_pend.next_pc = o_res.next_pc;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/ceau_pending.sv */
// Pending pointer request register.
`timescale 1ns / 1ps
`default_nettype none

module ceau_pending (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  var ceau_pkg::t_pend i_next,
    output ceau_pkg::t_pend     o_pend
);

    ceau_pkg::t_pend r_pend;
    ceau_pkg::t_pend n_pend;

    always_comb begin
        n_pend = i_load ? i_next : r_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    assign o_pend = r_pend;

endmodule

`default_nettype wire

/* hdl/cpu_effective_address_unit.sv */
// Top level of the effective address unit: input register, resolver, result register.
//
// channel  direction  handshake                 payload
// in       sink       i_in_valid / o_in_stall   command, mode, pc, operands, indexes, pointer
// out      source     o_out_valid / i_out_stall address, flags, next_pc, pointer addresses
//
// One transaction per cycle unless stalled; results are offered from the result register.
// The pending pointer state updates as a transaction moves into the result register,
// so the transaction behind it sees the new state.
// Reset clears both stage valids and the pending state.
// An output stall holds the result register and then backs up the input register.
`timescale 1ns / 1ps
`default_nettype none

module cpu_effective_address_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_command,
    input  wire  [3:0]  i_mode,
    input  wire  [15:0] i_pc,
    input  wire  [7:0]  i_operand_lo,
    input  wire  [7:0]  i_operand_hi,
    input  wire  [7:0]  i_index_x,
    input  wire  [7:0]  i_index_y,
    input  wire  [7:0]  i_pointer_lo,
    input  wire  [7:0]  i_pointer_hi,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [15:0] o_address,
    output logic        o_page_crossed,
    output logic [15:0] o_next_pc,
    output logic        o_needs_pointer,
    output logic [15:0] o_pointer_lo_address,
    output logic [15:0] o_pointer_hi_address,
    output logic        o_protocol_error
);

    logic                r_in_valid;
    logic                n_in_valid;
    ceau_pkg::t_in_item  r_in;
    logic                r_out_valid;
    logic                n_out_valid;
    ceau_pkg::t_out_item r_out;

    logic                out_free;
    logic                in_take;
    logic                advance;
    ceau_pkg::t_out_item res;
    ceau_pkg::t_pend     pend;
    ceau_pkg::t_pend     pend_next;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign advance    = r_in_valid && out_free;

    always_comb begin
        n_in_valid = in_take ? 1'b1 : (out_free ? 1'b0 : r_in_valid);
        n_out_valid = out_free ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.command    <= i_command;
            r_in.mode       <= i_mode;
            r_in.pc         <= i_pc;
            r_in.operand_lo <= i_operand_lo;
            r_in.operand_hi <= i_operand_hi;
            r_in.index_x    <= i_index_x;
            r_in.index_y    <= i_index_y;
            r_in.pointer_lo <= i_pointer_lo;
            r_in.pointer_hi <= i_pointer_hi;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    ceau_resolve u_resolve (
        .i_item (r_in),
        .i_pend (pend),
        .o_res  (res),
        .o_pend (pend_next)
    );

    ceau_pending u_pending (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_next  (pend_next),
        .o_pend  (pend)
    );

    assign o_out_valid          = r_out_valid;
    assign o_address            = r_out.address;
    assign o_page_crossed       = r_out.page_crossed;
    assign o_next_pc            = r_out.next_pc;
    assign o_needs_pointer      = r_out.needs_pointer;
    assign o_pointer_lo_address = r_out.pointer_lo_address;
    assign o_pointer_hi_address = r_out.pointer_hi_address;
    assign o_protocol_error     = r_out.protocol_error;

endmodule

`default_nettype wire

/* hdl/ceau_checker.sv */
// Port-level checks for the effective address unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ceau_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [15:0] o_address,
    input wire        o_page_crossed,
    input wire [15:0] o_next_pc,
    input wire        o_needs_pointer,
    input wire [15:0] o_pointer_lo_address,
    input wire [15:0] o_pointer_hi_address,
    input wire        o_protocol_error
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_protocol_error |->
            o_address == 16'h0000 && o_next_pc == 16'h0000 && !o_needs_pointer
            && !o_page_crossed)
        else $error("error transaction carries data");

    a_pending_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_needs_pointer |-> o_address == 16'h0000 && !o_page_crossed
            && !o_protocol_error)
        else $error("pointer request with an address");

    a_no_ptr_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_needs_pointer |->
            o_pointer_lo_address == 16'h0000 && o_pointer_hi_address == 16'h0000)
        else $error("pointer addresses without a request");

endmodule

bind cpu_effective_address_unit ceau_checker u_ceau_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_address            (o_address),
    .o_page_crossed       (o_page_crossed),
    .o_next_pc            (o_next_pc),
    .o_needs_pointer      (o_needs_pointer),
    .o_pointer_lo_address (o_pointer_lo_address),
    .o_pointer_hi_address (o_pointer_hi_address),
    .o_protocol_error     (o_protocol_error)
);

`default_nettype wire
